>>> rtl/core/bfa_pkg.sv
// Shared types and constants for the first-fit bitmap block allocator.
package bfa_pkg;

   // default geometry of the free map
   localparam int MAP_WORDS_DEF = 1024;
   localparam int WORD_BITS_DEF = 32;

   // fixed field widths of the channel words
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int BLOCK_W = 15;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] word_index;
      logic [VALUE_W-1:0] word_value;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [BLOCK_W-1:0] block_number;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/core/bfa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bitmap_first_free_allocator.sv
// Load: the word is written to the map when accepted and in range; no result.
// Allocate: the lowest set bit of the first nonzero map word, from word 0 upward,
// is cleared and returned as block_number (ok low when the map is empty). The result
// word is registered once the output register is not stalled; one map word is read
// per cycle from the single RAM read port. One item is in work at a time; the next
// is taken once the result is in the output register. After reset a clearing sweep
// zeroes all MAP_WORDS map words (1024 by default); req_stall stays high during it.
module bitmap_first_free_allocator
   import bfa_pkg::*;
#(
   parameter int MAP_WORDS = MAP_WORDS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW = $clog2(WORD_BITS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

   state_type        state_ff, state_in;
   logic [AW-1:0]    addr_ff, addr_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;

   logic             req_accept;
   logic             load_in_range;
   logic [WORD_BITS-1:0] low_bit;
   logic [BW-1:0]    bit_idx;
   logic             out_free;

   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_in_range = ({7'b0, req_data.word_index} < 17'(MAP_WORDS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // lowest set bit of the word just read
   assign low_bit = rd_data & (~rd_data + WORD_BITS'(1));
   always_comb begin
      bit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (rd_data[i]) begin
            bit_idx = BW'(i);
         end
      end
   end

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // next state, map accesses and result handling
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = addr_ff + AW'(1);

      unique case (state_ff)
         // zero one map word per cycle after reset
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end

         // take a load or start an allocation scan at word 0
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.kind == KIND_LOAD) begin
                  wr_en   = load_in_range;
                  wr_addr = AW'(req_data.word_index);
                  wr_data = WORD_BITS'(req_data.word_value);
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  addr_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         // examine word addr_ff, prefetch the next one
         ST_SCAN: begin
            if (rd_data != '0) begin
               wr_en   = 1'b1;
               wr_data = rd_data & ~low_bit;
               res_in.ok = 1'b1;
               res_in.block_number =
                  BLOCK_W'(32'(addr_ff) * 32'(WORD_BITS) + 32'(bit_idx));
               state_in = ST_FINISH;
            end else if (addr_ff == LAST_ADDR) begin
               res_in.ok           = 1'b0;
               res_in.block_number = '0;
               state_in = ST_FINISH;
            end else begin
               rd_en   = 1'b1;
               addr_in = addr_ff + AW'(1);
            end
         end

         // hand the result to the output register once it is free
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/bitmap_first_free_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 1ps

module bitmap_first_free_allocator_tb;
   import bfa_pkg::*;

   localparam int MAP_WORDS        = MAP_WORDS_DEF;
   localparam int WORD_BITS        = WORD_BITS_DEF;
   localparam int RANDOM_PER_PHASE = 136;
   localparam int HOLD_LEN         = 400;
   localparam int QUIET_LIMIT      = 20000;
   localparam int TAIL_CYCLES      = MAP_WORDS + 8;

   // one stimulus word, with its expected result where it is typed in
   typedef struct packed {
      req_type word;
      logic    fixed;
      rsp_type want;
   } plan_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type      req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type      rsp_data;
   plan_row_type cur_row   = '0;

   // predicted free map and results still owed by the block
   logic [WORD_BITS-1:0] model_map [MAP_WORDS];
   rsp_type              awaited_allocs [$];
   plan_row_type         plan_q [$];

   int   error_count  = 0;
   int   quiet_cycles = 0;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   logic hold_req     = 1'b0;
   int   hold_count   = 0;

   bitmap_first_free_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // lowest free block: words upward, bits from the LSB; claims the bit it finds
   function automatic rsp_type take_first_free();
      rsp_type grant;
      grant = '0;
      for (int w = 0; w < MAP_WORDS; w++) begin
         if (model_map[w] != '0) begin
            for (int b = 0; b < WORD_BITS; b++) begin
               if (model_map[w][b]) begin
                  model_map[w][b]    = 1'b0;
                  grant.ok           = 1'b1;
                  grant.block_number = BLOCK_W'(w * WORD_BITS + b);
                  return grant;
               end
            end
         end
      end
      return grant;
   endfunction

   function automatic void add_row(logic kind, int idx, logic [VALUE_W-1:0] value,
                                   logic fixed, logic ok, int bn);
      plan_row_type row;
      row.word.kind         = kind;
      row.word.word_index   = INDEX_W'(idx);
      row.word.word_value   = value;
      row.fixed             = fixed;
      row.want.ok           = ok;
      row.want.block_number = BLOCK_W'(bn);
      plan_q.push_back(row);
   endfunction

   function automatic plan_row_type random_row();
      plan_row_type row;
      int pick;
      row = '0;
      row.word.word_index = INDEX_W'($urandom);
      row.word.word_value = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
         // index and value ride along as noise on an allocate
         row.word.kind = KIND_ALLOC;
      end else begin
         row.word.kind = KIND_LOAD;
         // mostly low words so scans stay short, the rest anywhere in the map
         if ($urandom_range(0, 4) != 0) row.word.word_index = INDEX_W'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 20) row.word.word_value = 32'h1 << $urandom_range(0, 31);
         else if (pick < 35) row.word.word_value = '0;
         else if (pick < 45) row.word.word_value = '1;
         else if (pick < 60) row.word.word_value = $urandom & $urandom & $urandom;
      end
      return row;
   endfunction

   // present one word, idling first at the current rate; returns on acceptance
   task automatic offer(input plan_row_type row);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row.word;
      cur_row   <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender goes quiet until every owed result is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_allocs.size() != 0) @(posedge clock);
   endtask

   // receiver: one long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_req && hold_count < HOLD_LEN) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // predict on each accepted request, check each accepted result, watchdog
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      logic    moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if (req_data.kind == KIND_LOAD) begin
               if (int'(req_data.word_index) < MAP_WORDS)
                  model_map[req_data.word_index] = req_data.word_value[WORD_BITS-1:0];
            end else begin
               want = take_first_free();
               if (cur_row.fixed) want = cur_row.want;
               awaited_allocs.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (awaited_allocs.size() == 0) begin
               $display("%0t: unexpected result word, ok %0b block %0d",
                        $time, rsp_data.ok, rsp_data.block_number);
               error_count++;
            end else begin
               want = awaited_allocs.pop_front();
               if (rsp_data.ok !== want.ok) begin
                  $display("%0t: ok mismatch, expected %0b, actual %0b",
                           $time, want.ok, rsp_data.ok);
                  error_count++;
               end
               if (rsp_data.block_number !== want.block_number) begin
                  $display("%0t: block_number mismatch, expected %0d, actual %0d",
                           $time, want.block_number, rsp_data.block_number);
                  error_count++;
               end
            end
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      foreach (model_map[i]) model_map[i] = '0;

      // directed rows: empty map, both map ends, word boundaries, map full
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b1, 1'b0, 0);
      add_row(KIND_LOAD,  0,    32'h0000_0001, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b1, 1'b1, 0);
      add_row(KIND_ALLOC, 1023, 32'hFFFF_FFFF, 1'b1, 1'b0, 0);
      add_row(KIND_LOAD,  1023, 32'h8000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b1, 1'b1, 32767);
      add_row(KIND_LOAD,  5,    32'hFFFF_FFFF, 1'b0, 1'b0, 0);
      add_row(KIND_LOAD,  1023, 32'hFFFF_FFFF, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b1, 1'b1, 160);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_LOAD,  5,    32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b1, 1'b1, 32736);
      add_row(KIND_LOAD,  682,  32'hAAAA_AAAA, 1'b0, 1'b0, 0);
      add_row(KIND_LOAD,  341,  32'h5555_5555, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_LOAD,  1023, 32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_LOAD,  341,  32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_LOAD,  682,  32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b1, 1'b0, 0);
      add_row(KIND_LOAD,  0,    32'hFFFF_FFFF, 1'b0, 1'b0, 0);
      add_row(KIND_LOAD,  1,    32'hFFFF_0000, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b0, 1'b0, 0);
      add_row(KIND_ALLOC, 0,    32'h0000_0000, 1'b0, 1'b0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) offer(plan_q[i]);
      wait_for_results();

      // random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
            1: begin req_idle_pct = 73; rsp_idle_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_idle_pct = 73; end
            default: begin req_idle_pct = 17; rsp_idle_pct = 17; end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) offer(random_row());

         // long receiver hold-off while allocates keep coming
         if (phase == 0) begin
            hold_req <= 1'b1;
            add_row(KIND_LOAD, 0, 32'hFFFF_FFFF, 1'b0, 1'b0, 0);
            offer(plan_q[plan_q.size() - 1]);
            for (int i = 0; i < 9; i++) begin
               add_row(KIND_ALLOC, $urandom_range(0, 1023), $urandom, 1'b0, 1'b0, 0);
               offer(plan_q[plan_q.size() - 1]);
            end
            while (hold_count < HOLD_LEN) @(posedge clock);
            hold_req <= 1'b0;
         end

         // sender pauses until every owed result is back
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && awaited_allocs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
